// ----- src/delta_sleep_queue_unit_assert.svh -----
// Assertion macros shared by the delta sleep queue RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef DELTA_SLEEP_QUEUE_UNIT_ASSERT_SVH
`define DELTA_SLEEP_QUEUE_UNIT_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define DSQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the condition holds, the expression holds in the same cycle.
`define DSQ_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// When the condition holds, the expression holds in the following cycle.
`define DSQ_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- src/dsq_pkg.sv -----
// Package for the delta sleep queue: sizes, operation and status codes,
// the shared arithmetic unit request type and the ring pointer helper. No dependencies.
package dsq_pkg;

    localparam int QueueDepth = 16;
    localparam int MaxOut     = 16;

    localparam int FuncW   = 2;
    localparam int IdW     = 16;
    localparam int DeltaW  = 32;
    localparam int CountW  = 7;
    localparam int StatusW = 3;

    localparam int AddrW   = $clog2(QueueDepth);
    localparam int CntW    = $clog2(QueueDepth + 1);
    localparam int PtrSumW = CntW + 1;
    localparam int SumW    = DeltaW + CntW;
    localparam int AluW    = SumW + 1;
    localparam int EntryW  = IdW + DeltaW;

    localparam logic [DeltaW-1:0] DeltaMax = '1;

    localparam logic [FuncW-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FuncW-1:0] FUNC_POP     = 2'd1;
    localparam logic [FuncW-1:0] FUNC_RELEASE = 2'd2;

    localparam logic [StatusW-1:0] ST_INSERTED = 3'd0;
    localparam logic [StatusW-1:0] ST_IGNORED  = 3'd1;
    localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
    localparam logic [StatusW-1:0] ST_POPPED   = 3'd3;
    localparam logic [StatusW-1:0] ST_NONE     = 3'd4;
    localparam logic [StatusW-1:0] ST_RELEASED = 3'd5;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic            op;
        logic [AluW-1:0] a;
        logic [AluW-1:0] b;
    } alu_req_t;

    // Physical slot of a logical queue position in the ring buffer.
    function automatic logic [AddrW-1:0] ptr_add(logic [AddrW-1:0] base,
                                                 logic [CntW-1:0] off);
        logic [PtrSumW-1:0] s;
        s = PtrSumW'(base) + PtrSumW'(off);
        if (s >= PtrSumW'(QueueDepth))
        begin
            s = s - PtrSumW'(QueueDepth);
        end
        return s[AddrW-1:0];
    endfunction

endpackage

// ----- src/dsq_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used for the queue entry storage.
module dsq_ram #(
    parameter int Width = 48,
    parameter int Depth = 16,
    localparam int AddrW = $clog2(Depth)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [Width-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [Width-1:0] rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/dsq_alu.sv -----
// Shared add/subtract unit of the delta sleep queue sequencer.
// Depends on dsq_pkg for the request type and operation codes.
module dsq_alu (
    input  dsq_pkg::alu_req_t              req,
    output logic [dsq_pkg::AluW-1:0]       res
);

    always_comb
    begin
        case (req.op)
            dsq_pkg::ALU_ADD: res = req.a + req.b;
            dsq_pkg::ALU_SUB: res = req.a - req.b;
            default:          res = req.a + req.b;
        endcase
    end

endmodule

// ----- src/delta_sleep_queue_unit.sv -----
// Top level of the delta sleep queue: sequencer, ring buffer control and output register.
// Depends on dsq_pkg, dsq_ram, dsq_alu and delta_sleep_queue_unit_assert.svh.

// The delta sleep queue keeps up to QueueDepth thread ids (16) in wake-up order, each with
// its wait relative to the entry ahead of it, in a ring buffer held in one RAM with a
// registered read port. A request transaction is accepted only while the sequencer is idle,
// and every request gives one or more result transactions; the final one carries last.
// An insert walks the running sum of deltas entry by entry to find the slot, moves every
// entry that must go behind the new one back by one slot, then fixes the successor's delta,
// writes the new entry and hands over the result. The walk goes through the single RAM
// read port and the single shared adder; the move goes through the RAM read and write
// ports only. Insert with a zero wait or into a full queue, and unknown operations, answer
// without touching the RAM. Pop and release hand out the released entries one at a time,
// then fold the summed deltas into the new head, if entries remain, with one more
// read-modify-write. A result stalled at the output holds the sequencer only when the next
// result is due; the next request is taken while the final result still waits in the output
// register. There is no clearing pass: the RAM is never read at a slot outside the occupied
// range in a way that matters.
module delta_sleep_queue_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dsq_pkg::FuncW-1:0]     func,
    input  logic [dsq_pkg::IdW-1:0]       thread_id,
    input  logic [dsq_pkg::DeltaW-1:0]    wait_ticks,
    input  logic [dsq_pkg::CountW-1:0]    release_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dsq_pkg::StatusW-1:0]   status,
    output logic [dsq_pkg::IdW-1:0]       out_thread_id,
    output logic                          last
);

    `include "delta_sleep_queue_unit_assert.svh"

    localparam int CntW   = dsq_pkg::CntW;
    localparam int AluW   = dsq_pkg::AluW;
    localparam int DeltaW = dsq_pkg::DeltaW;
    localparam int SumW   = dsq_pkg::SumW;
    localparam int CmpW   = (dsq_pkg::CountW > CntW) ? dsq_pkg::CountW : CntW;

    localparam logic [CntW-1:0] OccMax = CntW'(dsq_pkg::QueueDepth);
    localparam logic [CmpW-1:0] RelMax = CmpW'(dsq_pkg::MaxOut);

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WALK     = 4'd1;
    localparam logic [3:0] S_SHIFT_RD = 4'd2;
    localparam logic [3:0] S_SHIFT    = 4'd3;
    localparam logic [3:0] S_PLACE1   = 4'd4;
    localparam logic [3:0] S_PLACE0   = 4'd5;
    localparam logic [3:0] S_EMIT     = 4'd6;
    localparam logic [3:0] S_REL_OUT  = 4'd7;
    localparam logic [3:0] S_FOLD_WR  = 4'd8;

    // Control state.
    logic [3:0]                   state_reg, state_next;
    logic [dsq_pkg::AddrW-1:0]    head_reg, head_next;
    logic [CntW-1:0]              occ_reg, occ_next;
    logic                         out_valid_reg, out_valid_next;

    // Working registers of the current request.
    logic [CntW-1:0]              idx_reg, idx_next;
    logic [CntW-1:0]              pos_reg, pos_next;
    logic [CntW-1:0]              rel_n_reg, rel_n_next;
    logic [DeltaW:0]              cum_reg, cum_next;
    logic [DeltaW-1:0]            before_reg, before_next;
    logic [DeltaW-1:0]            ticks_reg, ticks_next;
    logic [dsq_pkg::IdW-1:0]      tid_reg, tid_next;
    logic [dsq_pkg::IdW-1:0]      succ_id_reg, succ_id_next;
    logic [SumW-1:0]              sum_reg, sum_next;
    logic [dsq_pkg::StatusW-1:0]  rel_status_reg, rel_status_next;
    logic [dsq_pkg::StatusW-1:0]  res_status_reg, res_status_next;

    // Output register.
    logic [dsq_pkg::StatusW-1:0]  out_status_reg, out_status_next;
    logic [dsq_pkg::IdW-1:0]      out_tid_reg, out_tid_next;
    logic                         out_last_reg, out_last_next;

    // RAM and shared adder.
    logic                         wr_en;
    logic [dsq_pkg::AddrW-1:0]    wr_addr;
    logic [dsq_pkg::EntryW-1:0]   wr_data;
    logic [dsq_pkg::AddrW-1:0]    rd_addr;
    logic [dsq_pkg::EntryW-1:0]   rd_data;
    logic [dsq_pkg::IdW-1:0]      rd_id;
    logic [DeltaW-1:0]            rd_delta;
    dsq_pkg::alu_req_t            alu_req;
    logic [AluW-1:0]              alu_res;

    // Helpers.
    logic                         slot_free;
    logic [CntW-1:0]              idx_inc, idx_dec, pos_inc, occ_dec, occ_after_rel;
    logic [CmpW-1:0]              cnt_clip, rel_clip;

    dsq_ram #(
        .Width (dsq_pkg::EntryW),
        .Depth (dsq_pkg::QueueDepth)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dsq_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign rd_id    = rd_data[dsq_pkg::EntryW-1:DeltaW];
    assign rd_delta = rd_data[DeltaW-1:0];

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign out_thread_id = out_tid_reg;
    assign last          = out_last_reg;

    // The output register may be reloaded when it is empty or being drained this cycle.
    assign slot_free = !out_valid_reg || out_ready;

    assign idx_inc       = idx_reg + CntW'(1);
    assign idx_dec       = idx_reg - CntW'(1);
    assign pos_inc       = pos_reg + CntW'(1);
    assign occ_dec       = occ_reg - CntW'(1);
    assign occ_after_rel = occ_reg - rel_n_reg;

    // Number of entries a release moves out: the smallest of count, occupancy and MaxOut.
    assign cnt_clip = (CmpW'(release_count) < CmpW'(occ_reg)) ? CmpW'(release_count)
                                                               : CmpW'(occ_reg);
    assign rel_clip = (cnt_clip < RelMax) ? cnt_clip : RelMax;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        rel_n_next      = rel_n_reg;
        cum_next        = cum_reg;
        before_next     = before_reg;
        ticks_next      = ticks_reg;
        tid_next        = tid_reg;
        succ_id_next    = succ_id_reg;
        sum_next        = sum_reg;
        rel_status_next = rel_status_reg;
        res_status_next = res_status_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_tid_next    = out_tid_reg;
        out_last_next   = out_last_reg;

        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = {succ_id_reg, rd_delta};

        alu_req.op = dsq_pkg::ALU_ADD;
        alu_req.a  = AluW'(cum_reg);
        alu_req.b  = AluW'(rd_delta);

        case (state_reg)
            S_IDLE:
            begin
                // The head is read every idle cycle so its entry is ready after accept.
                if (in_valid)
                begin
                    case (func)
                        dsq_pkg::FUNC_INSERT:
                        begin
                            tid_next    = thread_id;
                            ticks_next  = wait_ticks;
                            cum_next    = '0;
                            before_next = '0;
                            idx_next    = '0;
                            pos_next    = '0;
                            if (wait_ticks == '0)
                            begin
                                res_status_next = dsq_pkg::ST_IGNORED;
                                state_next      = S_EMIT;
                            end
                            else if (occ_reg == OccMax)
                            begin
                                res_status_next = dsq_pkg::ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (occ_reg == '0)
                            begin
                                state_next = S_PLACE0;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        dsq_pkg::FUNC_POP:
                        begin
                            idx_next        = '0;
                            sum_next        = '0;
                            rel_n_next      = CntW'(1);
                            rel_status_next = dsq_pkg::ST_POPPED;
                            if (occ_reg == '0)
                            begin
                                res_status_next = dsq_pkg::ST_NONE;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_REL_OUT;
                            end
                        end
                        dsq_pkg::FUNC_RELEASE:
                        begin
                            idx_next        = '0;
                            sum_next        = '0;
                            rel_n_next      = rel_clip[CntW-1:0];
                            rel_status_next = dsq_pkg::ST_RELEASED;
                            if (rel_clip == '0)
                            begin
                                res_status_next = dsq_pkg::ST_NONE;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_REL_OUT;
                            end
                        end
                        default:
                        begin
                            res_status_next = dsq_pkg::ST_NONE;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // The entry at idx arrives now; the next one is fetched in parallel.
                rd_addr = dsq_pkg::ptr_add(head_reg, idx_inc);
                if (alu_res > AluW'(ticks_reg))
                begin
                    pos_next     = idx_reg;
                    succ_id_next = rd_id;
                    cum_next     = alu_res[DeltaW:0];
                    before_next  = cum_reg[DeltaW-1:0];
                    state_next   = (idx_inc < occ_reg) ? S_SHIFT_RD : S_PLACE1;
                end
                else
                begin
                    cum_next    = alu_res[DeltaW:0];
                    before_next = alu_res[DeltaW-1:0];
                    if (idx_inc == occ_reg)
                    begin
                        pos_next   = occ_reg;
                        state_next = S_PLACE0;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end

            S_SHIFT_RD:
            begin
                rd_addr    = dsq_pkg::ptr_add(head_reg, occ_dec);
                idx_next   = occ_dec;
                state_next = S_SHIFT;
            end

            S_SHIFT:
            begin
                // Move one entry back by one slot while the one ahead of it is read.
                wr_en   = 1'b1;
                wr_addr = dsq_pkg::ptr_add(head_reg, idx_inc);
                wr_data = rd_data;
                rd_addr = dsq_pkg::ptr_add(head_reg, idx_dec);
                if (idx_reg > pos_inc)
                begin
                    idx_next = idx_dec;
                end
                else
                begin
                    state_next = S_PLACE1;
                end
            end

            S_PLACE1:
            begin
                // The old occupant of the slot keeps only the wait beyond the new entry.
                alu_req.op = dsq_pkg::ALU_SUB;
                alu_req.a  = AluW'(cum_reg);
                alu_req.b  = AluW'(ticks_reg);
                wr_en      = 1'b1;
                wr_addr    = dsq_pkg::ptr_add(head_reg, pos_inc);
                wr_data    = {succ_id_reg, alu_res[DeltaW-1:0]};
                state_next = S_PLACE0;
            end

            S_PLACE0:
            begin
                alu_req.op      = dsq_pkg::ALU_SUB;
                alu_req.a       = AluW'(ticks_reg);
                alu_req.b       = AluW'(before_reg);
                wr_en           = 1'b1;
                wr_addr         = dsq_pkg::ptr_add(head_reg, pos_reg);
                wr_data         = {tid_reg, alu_res[DeltaW-1:0]};
                occ_next        = occ_reg + CntW'(1);
                res_status_next = dsq_pkg::ST_INSERTED;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tid_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_REL_OUT:
            begin
                alu_req.a = AluW'(sum_reg);
                rd_addr   = dsq_pkg::ptr_add(head_reg, idx_reg);
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rel_status_reg;
                    out_tid_next    = rd_id;
                    out_last_next   = (idx_inc == rel_n_reg);
                    sum_next        = alu_res[SumW-1:0];
                    rd_addr         = dsq_pkg::ptr_add(head_reg, idx_inc);
                    if (idx_inc == rel_n_reg)
                    begin
                        // The read just issued fetches the new head for the fold.
                        head_next  = dsq_pkg::ptr_add(head_reg, rel_n_reg);
                        occ_next   = occ_after_rel;
                        state_next = (occ_after_rel != '0) ? S_FOLD_WR : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end

            S_FOLD_WR:
            begin
                // The released waits are added to the new head, saturating.
                alu_req.a  = AluW'(sum_reg);
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                wr_data    = {rd_id, (alu_res > AluW'(dsq_pkg::DeltaMax)) ?
                              dsq_pkg::DeltaMax : alu_res[DeltaW-1:0]};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        rel_n_reg      <= rel_n_next;
        cum_reg        <= cum_next;
        before_reg     <= before_next;
        ticks_reg      <= ticks_next;
        tid_reg        <= tid_next;
        succ_id_reg    <= succ_id_next;
        sum_reg        <= sum_next;
        rel_status_reg <= rel_status_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_tid_reg    <= out_tid_next;
        out_last_reg   <= out_last_next;
    end

    // The occupancy never exceeds the queue depth.
    `DSQ_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= OccMax, "occupancy above depth")

    // A walk only runs on a queue that has entries and room for one more.
    `DSQ_ASSERT_IMPLY(a_walk_room, clk, rst_n, state_reg == S_WALK,
        (occ_reg < OccMax) && (occ_reg != '0), "walk on empty or full queue")

    // The occupancy changes only when an entry is placed or a release finishes.
    `DSQ_ASSERT_NEXT(a_occ_hold, clk, rst_n,
        (state_reg != S_PLACE0) && (state_reg != S_REL_OUT), $stable(occ_reg),
        "occupancy changed outside place or release")

    // The release index stays inside the number of entries being released.
    `DSQ_ASSERT_IMPLY(a_rel_idx, clk, rst_n, state_reg == S_REL_OUT,
        (idx_reg < rel_n_reg) && (rel_n_reg <= occ_reg), "release index out of range")

endmodule

// ----- dv/tb_delta_sleep_queue_unit.sv -----
// Self-checking testbench for delta_sleep_queue_unit: random and directed sleep queue traffic.
// Depends on dsq_pkg and the delta_sleep_queue_unit RTL; it has no other inputs.
module tb_delta_sleep_queue_unit;

    localparam int FuncW      = dsq_pkg::FuncW;
    localparam int IdW        = dsq_pkg::IdW;
    localparam int DeltaW     = dsq_pkg::DeltaW;
    localparam int CountW     = dsq_pkg::CountW;
    localparam int StatusW    = dsq_pkg::StatusW;
    localparam int QueueDepth = dsq_pkg::QueueDepth;
    localparam int MaxOut     = dsq_pkg::MaxOut;

    // Operation code 3 is not defined by the block; it must answer with no effect.
    localparam logic [FuncW-1:0] FUNC_UNDEFINED = 2'd3;

    // One request transaction as the sender will present it, with the idle cycles
    // that come before it and an optional hold until every result has drained.
    typedef struct {
        logic [FuncW-1:0]  func;
        logic [IdW-1:0]    thread_id;
        logic [DeltaW-1:0] wait_ticks;
        logic [CountW-1:0] release_count;
        int                gap;
        bit                drain_first;
    } sleep_request_t;

    // One result transaction as the block should produce it.
    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [IdW-1:0]     thread_id;
        logic               last;
    } wakeup_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [FuncW-1:0]    func = '0;
    logic [IdW-1:0]      thread_id = '0;
    logic [DeltaW-1:0]   wait_ticks = '0;
    logic [CountW-1:0]   release_count = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [StatusW-1:0]  status;
    logic [IdW-1:0]      out_thread_id;
    logic                last;

    // Requests still to be presented, and results still owed by the block.
    sleep_request_t      sleep_requests[$];
    wakeup_t             owed_wakeups[$];

    // Shadow copy of the sleep queue: ids and relative waits, head at index 0.
    logic [IdW-1:0]      shadow_ids[QueueDepth];
    logic [DeltaW-1:0]   shadow_deltas[QueueDepth];
    int                  shadow_count = 0;

    int                  mismatch_count = 0;
    int                  requests_planned = 0;
    int unsigned         wakeups_seen = 0;
    bit                  sender_calm = 1'b0;
    bit                  pause_next = 1'b0;

    // Handshake flags captured at the rising edge and read at the next falling edge.
    logic                req_fire = 1'b0;
    logic                wake_fire = 1'b0;

    delta_sleep_queue_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .thread_id     (thread_id),
        .wait_ticks    (wait_ticks),
        .release_count (release_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_thread_id (out_thread_id),
        .last          (last)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void owe_wakeup(logic [StatusW-1:0] st, logic [IdW-1:0] id, logic lst);
        wakeup_t w;
        w.status    = st;
        w.thread_id = id;
        w.last      = lst;
        owed_wakeups.push_back(w);
    endfunction

    // Adds folded deltas to the new head; the head delta cannot exceed the all-ones value.
    function automatic logic [DeltaW-1:0] fold_delta(logic [DeltaW-1:0] a, logic [63:0] b);
        logic [63:0] s;
        s = {32'd0, a} + b;
        return (s > {32'd0, dsq_pkg::DeltaMax}) ? dsq_pkg::DeltaMax : s[DeltaW-1:0];
    endfunction

    // Drops the first n entries of the shadow queue and folds their summed waits
    // into whatever becomes the new head.
    function automatic void shadow_drop_head(int n);
        logic [63:0] sum;
        sum = 64'd0;
        for (int k = 0; k < n; k++)
        begin
            sum = sum + {32'd0, shadow_deltas[k]};
        end
        for (int k = 0; k + n < shadow_count; k++)
        begin
            shadow_ids[k]    = shadow_ids[k + n];
            shadow_deltas[k] = shadow_deltas[k + n];
        end
        shadow_count = shadow_count - n;
        if (shadow_count > 0)
        begin
            shadow_deltas[0] = fold_delta(shadow_deltas[0], sum);
        end
    endfunction

    // Applies one accepted request to the shadow queue and records the results it owes.
    function automatic void sleep_queue_apply(logic [FuncW-1:0] f, logic [IdW-1:0] id,
                                              logic [DeltaW-1:0] ticks, logic [CountW-1:0] cnt);
        logic [63:0]       cum;
        logic [63:0]       prior;
        logic [DeltaW-1:0] own_delta;
        int                slot;
        int                n;
        bit                found;
        cum   = 64'd0;
        prior = 64'd0;
        found = 1'b0;
        case (f)
            dsq_pkg::FUNC_INSERT:
            begin
                if (ticks == '0)
                begin
                    owe_wakeup(dsq_pkg::ST_IGNORED, '0, 1'b1);
                end
                else if (shadow_count >= QueueDepth)
                begin
                    owe_wakeup(dsq_pkg::ST_FULL, '0, 1'b1);
                end
                else
                begin
                    // The new entry goes in front of the first entry whose absolute wait
                    // is strictly larger, so equal waits keep arrival order.
                    slot = shadow_count;
                    for (int k = 0; k < shadow_count; k++)
                    begin
                        if (!found)
                        begin
                            cum = cum + {32'd0, shadow_deltas[k]};
                            if (cum > {32'd0, ticks})
                            begin
                                found = 1'b1;
                                slot  = k;
                            end
                            else
                            begin
                                prior = cum;
                            end
                        end
                    end
                    own_delta = ticks - prior[DeltaW-1:0];
                    if (slot < shadow_count)
                    begin
                        shadow_deltas[slot] = shadow_deltas[slot] - own_delta;
                    end
                    for (int k = shadow_count; k > slot; k--)
                    begin
                        shadow_ids[k]    = shadow_ids[k - 1];
                        shadow_deltas[k] = shadow_deltas[k - 1];
                    end
                    shadow_ids[slot]    = id;
                    shadow_deltas[slot] = own_delta;
                    shadow_count        = shadow_count + 1;
                    owe_wakeup(dsq_pkg::ST_INSERTED, '0, 1'b1);
                end
            end
            dsq_pkg::FUNC_POP:
            begin
                if (shadow_count == 0)
                begin
                    owe_wakeup(dsq_pkg::ST_NONE, '0, 1'b1);
                end
                else
                begin
                    owe_wakeup(dsq_pkg::ST_POPPED, shadow_ids[0], 1'b1);
                    shadow_drop_head(1);
                end
            end
            dsq_pkg::FUNC_RELEASE:
            begin
                n = int'(cnt);
                if (n > shadow_count)
                begin
                    n = shadow_count;
                end
                if (n > MaxOut)
                begin
                    n = MaxOut;
                end
                if (n == 0)
                begin
                    owe_wakeup(dsq_pkg::ST_NONE, '0, 1'b1);
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        owe_wakeup(dsq_pkg::ST_RELEASED, shadow_ids[k], k + 1 == n);
                    end
                    shadow_drop_head(n);
                end
            end
            default:
            begin
                owe_wakeup(dsq_pkg::ST_NONE, '0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(string what, wakeup_t want, wakeup_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch (%s): expected status %0d id %h last %b,",
                     what, want.status, want.thread_id, want.last,
                     " got status %0d id %h last %b",
                     got.status, got.thread_id, got.last);
        end
    endfunction

    // Requests are predicted when the block takes them, before results at the same
    // edge are compared, so the owed list is always up to date when a result arrives.
    always @(posedge clk)
    begin
        wakeup_t got;
        wakeup_t want;
        req_fire  <= in_valid && in_ready;
        wake_fire <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
        begin
            sleep_queue_apply(func, thread_id, wait_ticks, release_count);
        end
        if (rst_n && out_valid && out_ready)
        begin
            wakeups_seen++;
            got.status    = status;
            got.thread_id = out_thread_id;
            got.last      = last;
            if (owed_wakeups.size() == 0)
            begin
                want = '0;
                note_mismatch("result with nothing owed", want, got);
            end
            else
            begin
                want = owed_wakeups.pop_front();
                if (got.status !== want.status || got.thread_id !== want.thread_id ||
                    got.last !== want.last)
                begin
                    note_mismatch("field", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: presents queued requests at the falling edge. After a transaction is
    // taken, valid drops unless the next request is ready to go with no gap; the
    // valid line gets exactly one assignment per step either way.
    // ------------------------------------------------------------------

    sleep_request_t cur_request;
    bit             holding_request = 1'b0;
    int             send_gap_left = 0;

    always @(negedge clk)
    begin : sender
        logic drive_next;
        if (rst_n)
        begin
            drive_next = in_valid && !req_fire;
            if (!drive_next)
            begin
                if (!holding_request && sleep_requests.size() > 0)
                begin
                    cur_request     = sleep_requests.pop_front();
                    holding_request = 1'b1;
                    send_gap_left   = cur_request.gap;
                end
                if (holding_request)
                begin
                    if (send_gap_left > 0)
                    begin
                        send_gap_left--;
                    end
                    else if (!cur_request.drain_first || owed_wakeups.size() == 0)
                    begin
                        // A drain request waits until the block has handed over every result.
                        drive_next      = 1'b1;
                        holding_request = 1'b0;
                        func          <= cur_request.func;
                        thread_id     <= cur_request.thread_id;
                        wait_ticks    <= cur_request.wait_ticks;
                        release_count <= cur_request.release_count;
                    end
                end
            end
            in_valid <= drive_next;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: draws a random stall after each result, except in calm
    // stretches where it takes every result at once.
    // ------------------------------------------------------------------

    int recv_stall_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (wake_fire)
            begin
                recv_stall_left = ((wakeups_seen / 48) % 3 == 1) ? 0 : $urandom_range(0, 5);
            end
            if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void plan_request(logic [FuncW-1:0] f, logic [IdW-1:0] id,
                                         logic [DeltaW-1:0] ticks, logic [CountW-1:0] cnt);
        sleep_request_t r;
        r.func          = f;
        r.thread_id     = id;
        r.wait_ticks    = ticks;
        r.release_count = cnt;
        r.gap           = sender_calm ? 0 : $urandom_range(0, 5);
        r.drain_first   = pause_next;
        pause_next      = 1'b0;
        sleep_requests.push_back(r);
        requests_planned++;
        // The sender runs without gaps in every third stretch of 40 requests.
        sender_calm = ((requests_planned / 40) % 3 == 1);
    endfunction

    // Wait values lean toward small numbers so that equal waits collide often.
    function automatic logic [DeltaW-1:0] pick_wait();
        logic [DeltaW-1:0] w;
        case ($urandom_range(0, 15))
            0:       w = '0;
            1:       w = dsq_pkg::DeltaMax;
            2:       w = 32'd1 << $urandom_range(0, 31);
            3, 4, 5, 6, 7, 8:
                     w = $urandom_range(1, 40);
            9, 10:   w = $urandom_range(1, 1000);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic logic [CountW-1:0] pick_count();
        logic [CountW-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = 7'd64;
            1:       c = 7'd16;
            2, 3:    c = CountW'($urandom_range(0, 64));
            default: c = CountW'($urandom_range(0, 3));
        endcase
        return c;
    endfunction

    initial
    begin
        int pick;

        // Directed part: empty queue corners first.
        plan_request(dsq_pkg::FUNC_POP, 16'h1234, 32'd5, 7'd1);
        plan_request(dsq_pkg::FUNC_RELEASE, 16'h0000, 32'd0, 7'd5);
        plan_request(FUNC_UNDEFINED, 16'hFFFF, dsq_pkg::DeltaMax, 7'd64);
        plan_request(dsq_pkg::FUNC_INSERT, 16'hABCD, 32'd0, 7'd0);
        // Fill the queue: extreme ids and waits, equal waits that must keep arrival
        // order, and entries landing at head, middle and tail.
        plan_request(dsq_pkg::FUNC_INSERT, 16'hFFFF, dsq_pkg::DeltaMax, 7'd0);
        plan_request(dsq_pkg::FUNC_INSERT, 16'h0000, 32'd1, 7'h7F);
        plan_request(dsq_pkg::FUNC_INSERT, 16'h0100, 32'd100, 7'd0);
        plan_request(dsq_pkg::FUNC_INSERT, 16'h0101, 32'd100, 7'd0);
        plan_request(dsq_pkg::FUNC_INSERT, 16'h0050, 32'd50, 7'd0);
        plan_request(dsq_pkg::FUNC_INSERT, 16'h7FFF, dsq_pkg::DeltaMax, 7'd0);
        plan_request(dsq_pkg::FUNC_INSERT, 16'h8000, 32'h8000_0000, 7'd0);
        for (int k = 0; k < 9; k++)
        begin
            plan_request(dsq_pkg::FUNC_INSERT, 16'h0200 + IdW'(k), 32'd1 + 32'(k) * 32'd7,
                         7'd0);
        end
        // The queue now holds every slot, so one more insert is refused.
        plan_request(dsq_pkg::FUNC_INSERT, 16'h5555, 32'd3, 7'd0);
        plan_request(dsq_pkg::FUNC_RELEASE, 16'h0000, 32'd0, 7'd0);
        plan_request(dsq_pkg::FUNC_POP, 16'h0000, 32'd0, 7'd0);
        plan_request(dsq_pkg::FUNC_RELEASE, 16'h0000, 32'd0, 7'd3);
        pause_next = 1'b1;
        plan_request(dsq_pkg::FUNC_RELEASE, 16'h0000, 32'd0, 7'd64);

        // Random part: mostly single operations weighted toward insert so the queue
        // swings between empty and full, with occasional fill-to-full sequences.
        while (requests_planned < 360)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                for (int k = 0; k < QueueDepth + 1; k++)
                begin
                    plan_request(dsq_pkg::FUNC_INSERT, IdW'($urandom),
                                 $urandom_range(1, 60), CountW'($urandom));
                end
                plan_request(dsq_pkg::FUNC_RELEASE, IdW'($urandom), $urandom, 7'd64);
            end
            else
            begin
                if (pick < 7)
                begin
                    pause_next = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 52)
                begin
                    plan_request(dsq_pkg::FUNC_INSERT, IdW'($urandom), pick_wait(),
                                 CountW'($urandom));
                end
                else if (pick < 72)
                begin
                    plan_request(dsq_pkg::FUNC_POP, IdW'($urandom), $urandom,
                                 CountW'($urandom));
                end
                else if (pick < 97)
                begin
                    plan_request(dsq_pkg::FUNC_RELEASE, IdW'($urandom), $urandom,
                                 pick_count());
                end
                else
                begin
                    plan_request(FUNC_UNDEFINED, IdW'($urandom), $urandom, CountW'($urandom));
                end
            end
        end

        // Reset once, then let the sender and receiver run.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sleep_requests.size() != 0 || holding_request || in_valid)
        begin
            @(posedge clk);
        end
        while (owed_wakeups.size() != 0)
        begin
            @(posedge clk);
        end
        // Any stray result would show up within a full insert's latency.
        repeat (QueueDepth * 3) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #800000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/dsq_pkg.sv
src/dsq_ram.sv
src/dsq_alu.sv
src/delta_sleep_queue_unit.sv
dv/tb_delta_sleep_queue_unit.sv
